/* design/hxp_pkg.sv */
// Shared constants, beat types and helper functions for the hex tile pick pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package hxp_pkg;

   localparam int SIDE_LENGTH = 36;
   localparam int FRAC_BITS   = 4;

   localparam int POS_W  = 20;
   localparam int TILE_W = 12;
   localparam int GX_W   = 13;   // guess x, about +/-830
   localparam int GY_W   = 11;   // guess y, about +/-607
   localparam int M_W    = 14;   // 2*gx + gy
   localparam int KM_W   = 46;
   localparam int DX_W   = 47;
   localparam int EY_W   = 24;
   localparam int MAG_W  = 23;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 1;

   localparam longint SQRT3_Q20 = 1816187;

   // Guess divisor 3*side*2^frac = 1728 = 2^6 * 27; the /27 is an exact
   // reciprocal multiply for 16-bit dividends.
   localparam int     TILE_DIV    = 3 * SIDE_LENGTH * (1 << FRAC_BITS);
   localparam int     DIV_SHIFT   = 6;
   localparam longint RECIP       = 77673;
   localparam int     RECIP_SHIFT = 21;

   // Horizontal center step per unit of (2x+y), in offset units.
   localparam longint K_STEP = SQRT3_Q20 * SIDE_LENGTH * (1 << FRAC_BITS);

   // Offset magnitudes clamp here; anything this far can never beat the start.
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   localparam longint START_MAG = 20 * SIDE_LENGTH * (1 << FRAC_BITS) * 512;
   localparam logic [DIST_W-1:0] START_SQ = DIST_W'(START_MAG * START_MAG);

   localparam int N_DX = 7;   // distinct horizontal offsets, (2x+y) shift -3..+3
   localparam int N_DY = 3;
   localparam int N_LIST = 10; // start entry plus nine neighbors

   localparam int PIPE_DEPTH = 8;
   localparam int CNT_W      = 4;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
   } pos_pair_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [GX_W-1:0]  gx;
      logic signed [GY_W-1:0]  gy;
   } guess_type;

   typedef struct packed {
      logic [N_DX-1:0][SQ_W-1:0] ax_sq;
      logic [N_DY-1:0][SQ_W-1:0] ay_sq;
      logic signed [GX_W-1:0]    gx;
      logic signed [GY_W-1:0]    gy;
   } sq_type;

   typedef struct packed {
      logic signed [1:0]   dxo;
      logic signed [1:0]   dyo;
      logic [DIST_W-1:0]   range_sq;
   } pick_type;

   typedef struct packed {
      logic signed [TILE_W-1:0] tile_x;
      logic signed [TILE_W-1:0] tile_y;
   } tile_type;

   // Earlier entry wins ties.
   function automatic pick_type pick(input pick_type a, input pick_type b);
      pick_type r;
      r = (b.range_sq < a.range_sq) ? b : a;
      return r;
   endfunction

   function automatic logic signed [TILE_W-1:0] sat_tile(input logic signed [M_W-1:0] v);
      logic signed [TILE_W-1:0] r;
      if (v > M_W'(2047))
         r = 12'sd2047;
      else if (v < -M_W'(2048))
         r = -12'sd2048;
      else
         r = v[TILE_W-1:0];
      return r;
   endfunction

endpackage

/* design/hxp_req_if.sv */
// Request channel: valid/ready handshake carrying one screen position per beat.
// Depends on hxp_pkg for field widths.
interface hxp_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [hxp_pkg::POS_W-1:0] pos_x;
   logic signed [hxp_pkg::POS_W-1:0] pos_y;

   modport source (output valid, output pos_x, output pos_y, input ready);
   modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

/* design/hxp_rsp_if.sv */
// Response channel: valid/ready handshake carrying one tile coordinate pair per beat.
// Depends on hxp_pkg for field widths.
interface hxp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [hxp_pkg::TILE_W-1:0] tile_x;
   logic signed [hxp_pkg::TILE_W-1:0] tile_y;

   modport source (output valid, output tile_x, output tile_y, input ready);
   modport sink   (input valid, input tile_x, input tile_y, output ready);
endinterface

/* design/pixel_to_hex_tile_pick_top.sv */
// Hex tile pick: maps a signed fixed-point screen position (4 fraction bits) to the
// axial coordinates of the nearest hex tile of side 36, saturated to 12 bits.
// Fully pipelined over 8 register stages: one beat is accepted per clock unless a
// stalled response side holds the pipeline full; its result is registered through
// stages A to H and presented from the output register. The depth is set by the
// guess divide (2 stages), the offset and square unit (3 stages) and the compare
// tree with output register (3 stages). Each stage holds its beat only while the
// next one is full and stalled, so bubbles close up under back-pressure and up to
// 8 beats can be in flight. No configuration, no state between beats. Depends on
// hxp_pkg, hxp_req_if, hxp_rsp_if and the stage modules.
module pixel_to_hex_tile_pick_top (
   input  logic      clock,
   input  logic      reset,
   hxp_req_if.sink   req_bus,
   hxp_rsp_if.source rsp_bus
);

   hxp_pkg::pos_pair_type req_beat;
   hxp_pkg::guess_type    guess_beat;
   hxp_pkg::sq_type       sq_beat;
   hxp_pkg::tile_type     tile_beat;
   logic                  guess_valid, guess_ready;
   logic                  sq_valid, sq_ready;

   assign req_beat.pos_x = req_bus.pos_x;
   assign req_beat.pos_y = req_bus.pos_y;

   hxp_guess u_guess (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_beat   (req_beat),
      .out_valid (guess_valid),
      .out_ready (guess_ready),
      .out_beat  (guess_beat)
   );

   hxp_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (guess_valid),
      .in_ready  (guess_ready),
      .in_beat   (guess_beat),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_beat  (sq_beat)
   );

   hxp_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_beat   (sq_beat),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_beat  (tile_beat)
   );

   assign rsp_bus.tile_x = tile_beat.tile_x;
   assign rsp_bus.tile_y = tile_beat.tile_y;

endmodule

/* design/hxp_guess.sv */
// Two-stage front end: forms the truncated axial guess (gx, gy) for a position.
// Depends on hxp_pkg.
module hxp_guess (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hxp_pkg::pos_pair_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hxp_pkg::guess_type    out_beat
);

   logic signed [43:0] num;
   logic [43:0]        num_mag;
   logic [20:0]        y2_mag;
   logic signed [20:0] y2;

   logic                  a_valid_ff;
   logic                  a_en;
   logic [15:0]           a_xhi_ff, a_xhi_in;
   logic [15:0]           a_yhi_ff, a_yhi_in;
   logic                  a_xneg_ff, a_xneg_in;
   logic                  a_yneg_ff, a_yneg_in;
   hxp_pkg::pos_pair_type a_pos_ff;

   logic [33:0]        qx_prod;
   logic [33:0]        qy_prod;
   logic [11:0]        qx;
   logic [9:0]         qy;

   logic               b_valid_ff;
   logic               b_en;
   hxp_pkg::guess_type b_ff, b_in;

   assign b_en     = !b_valid_ff || out_ready;
   assign a_en     = !a_valid_ff || b_en;
   assign in_ready = a_en;

   // Stage A: numerator magnitudes, pre-shifted by 2^20 and by the power-of-two
   // part of the divisor.
   always_comb begin
      num = 44'(hxp_pkg::SQRT3_Q20) * 44'(in_beat.pos_x) - (44'(in_beat.pos_y) <<< 20);
      num_mag = num[43] ? 44'(-num) : 44'(num);
      y2 = $signed({in_beat.pos_y, 1'b0});
      y2_mag = y2[20] ? 21'(-y2) : 21'(y2);
      a_xhi_in  = num_mag[20 + hxp_pkg::DIV_SHIFT +: 16];
      a_yhi_in  = 16'(y2_mag[20:hxp_pkg::DIV_SHIFT]);
      a_xneg_in = num[43];
      a_yneg_in = y2[20];
   end

   // Stage B: divide by 27 with the reciprocal, then put the sign back.
   always_comb begin
      qx_prod = 34'(a_xhi_ff) * 34'(hxp_pkg::RECIP);
      qy_prod = 34'(a_yhi_ff) * 34'(hxp_pkg::RECIP);
      qx = qx_prod[hxp_pkg::RECIP_SHIFT +: 12];
      qy = qy_prod[hxp_pkg::RECIP_SHIFT +: 10];
      b_in.pos_x = a_pos_ff.pos_x;
      b_in.pos_y = a_pos_ff.pos_y;
      b_in.gx = a_xneg_ff ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      b_in.gy = a_yneg_ff ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_en) a_valid_ff <= in_valid;
         if (b_en) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_xhi_ff  <= a_xhi_in;
         a_yhi_ff  <= a_yhi_in;
         a_xneg_ff <= a_xneg_in;
         a_yneg_ff <= a_yneg_in;
         a_pos_ff  <= in_beat;
      end
      if (b_en) b_ff <= b_in;
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_ff;

endmodule

/* design/hxp_dist.sv */
// Three-stage distance unit: offsets of the nine neighbor centers, clamped
// magnitudes, then their squares. Depends on hxp_pkg.
module hxp_dist (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hxp_pkg::guess_type in_beat,
   output logic               out_valid,
   input  logic               out_ready,
   output hxp_pkg::sq_type    out_beat
);

   logic signed [hxp_pkg::M_W-1:0] m0;

   logic                              c_valid_ff;
   logic                              c_en;
   logic signed [hxp_pkg::KM_W-1:0]   c_km_ff, c_km_in;
   logic signed [hxp_pkg::EY_W-1:0]   c_e0_ff, c_e0_in;
   logic signed [hxp_pkg::POS_W-1:0]  c_pos_x_ff;
   logic signed [hxp_pkg::GX_W-1:0]   c_gx_ff;
   logic signed [hxp_pkg::GY_W-1:0]   c_gy_ff;

   logic signed [hxp_pkg::DX_W-1:0]   dx [hxp_pkg::N_DX];
   logic [hxp_pkg::DX_W-1:0]          dx_mag [hxp_pkg::N_DX];
   logic signed [hxp_pkg::EY_W-1:0]   ey [hxp_pkg::N_DY];
   logic [hxp_pkg::EY_W-1:0]          ey_mag [hxp_pkg::N_DY];

   logic                                           d_valid_ff;
   logic                                           d_en;
   logic [hxp_pkg::N_DX-1:0][hxp_pkg::MAG_W-1:0]   d_ax_ff, d_ax_in;
   logic [hxp_pkg::N_DY-1:0][hxp_pkg::MAG_W-1:0]   d_ay_ff, d_ay_in;
   logic signed [hxp_pkg::GX_W-1:0]                d_gx_ff;
   logic signed [hxp_pkg::GY_W-1:0]                d_gy_ff;

   logic            e_valid_ff;
   logic            e_en;
   hxp_pkg::sq_type e_ff, e_in;

   assign e_en     = !e_valid_ff || out_ready;
   assign d_en     = !d_valid_ff || e_en;
   assign c_en     = !c_valid_ff || d_en;
   assign in_ready = c_en;

   // Stage C: center of the guess tile; neighbors differ from it by constants.
   always_comb begin
      m0 = $signed({in_beat.gx, 1'b0}) + hxp_pkg::M_W'(in_beat.gy);
      c_km_in = hxp_pkg::KM_W'(hxp_pkg::K_STEP) * hxp_pkg::KM_W'(m0);
      c_e0_in = hxp_pkg::EY_W'($signed({in_beat.pos_y, 1'b0}))
              - hxp_pkg::EY_W'(hxp_pkg::TILE_DIV) * hxp_pkg::EY_W'(in_beat.gy);
   end

   // Stage D: horizontal offsets for (2x+y) shifts -3..+3, vertical for y -1..+1.
   always_comb begin
      for (int k = 0; k < hxp_pkg::N_DX; k++) begin
         dx[k] = (hxp_pkg::DX_W'(c_pos_x_ff) <<< 21) - hxp_pkg::DX_W'(c_km_ff)
               - hxp_pkg::DX_W'(hxp_pkg::K_STEP * longint'(k - 3));
         dx_mag[k] = dx[k][hxp_pkg::DX_W-1] ? hxp_pkg::DX_W'(-dx[k]) : hxp_pkg::DX_W'(dx[k]);
         d_ax_in[k] = (|dx_mag[k][hxp_pkg::DX_W-1:12 + hxp_pkg::MAG_W]) ?
                      hxp_pkg::MAG_MAX : dx_mag[k][12 +: hxp_pkg::MAG_W];
      end
      // Vertical offset is an exact multiple of 2^20, so the drop of 12 bits
      // becomes a left shift by 8.
      for (int j = 0; j < hxp_pkg::N_DY; j++) begin
         ey[j] = c_e0_ff - hxp_pkg::EY_W'(hxp_pkg::TILE_DIV * (j - 1));
         ey_mag[j] = ey[j][hxp_pkg::EY_W-1] ? hxp_pkg::EY_W'(-ey[j]) : hxp_pkg::EY_W'(ey[j]);
         d_ay_in[j] = (|ey_mag[j][hxp_pkg::EY_W-1:15]) ?
                      hxp_pkg::MAG_MAX : {ey_mag[j][14:0], 8'b0};
      end
   end

   // Stage E: squares.
   always_comb begin
      for (int k = 0; k < hxp_pkg::N_DX; k++)
         e_in.ax_sq[k] = hxp_pkg::SQ_W'(d_ax_ff[k]) * hxp_pkg::SQ_W'(d_ax_ff[k]);
      for (int j = 0; j < hxp_pkg::N_DY; j++)
         e_in.ay_sq[j] = hxp_pkg::SQ_W'(d_ay_ff[j]) * hxp_pkg::SQ_W'(d_ay_ff[j]);
      e_in.gx = d_gx_ff;
      e_in.gy = d_gy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_en) c_valid_ff <= in_valid;
         if (d_en) d_valid_ff <= c_valid_ff;
         if (e_en) e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_km_ff    <= c_km_in;
         c_e0_ff    <= c_e0_in;
         c_pos_x_ff <= in_beat.pos_x;
         c_gx_ff    <= in_beat.gx;
         c_gy_ff    <= in_beat.gy;
      end
      if (d_en) begin
         d_ax_ff <= d_ax_in;
         d_ay_ff <= d_ay_in;
         d_gx_ff <= c_gx_ff;
         d_gy_ff <= c_gy_ff;
      end
      if (e_en) e_ff <= e_in;
   end

   assign out_valid = e_valid_ff;
   assign out_beat  = e_ff;

endmodule

/* design/hxp_select.sv */
// Three-stage selection: sums squared distances, reduces the ten-entry list in
// a registered compare tree, then forms and saturates the tile. Depends on hxp_pkg.
module hxp_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hxp_pkg::sq_type   in_beat,
   output logic              out_valid,
   input  logic              out_ready,
   output hxp_pkg::tile_type out_beat
);

   // Entry 0 is the starting best (the guess itself); entries 1..9 are the
   // neighbors in search order, x outer. Earlier entries win ties.
   hxp_pkg::pick_type list [hxp_pkg::N_LIST];

   logic                            f_valid_ff;
   logic                            f_en;
   hxp_pkg::pick_type               f_pick_ff [5];
   hxp_pkg::pick_type               f_pick_in [5];
   logic signed [hxp_pkg::GX_W-1:0] f_gx_ff;
   logic signed [hxp_pkg::GY_W-1:0] f_gy_ff;

   hxp_pkg::pick_type               q0, q1;
   logic                            g_valid_ff;
   logic                            g_en;
   hxp_pkg::pick_type               g_r0_ff, g_r0_in;
   hxp_pkg::pick_type               g_r1_ff;
   logic signed [hxp_pkg::GX_W-1:0] g_gx_ff;
   logic signed [hxp_pkg::GY_W-1:0] g_gy_ff;

   hxp_pkg::pick_type               win;
   logic signed [hxp_pkg::M_W-1:0]  bx, by;
   logic                            h_valid_ff;
   logic                            h_en;
   hxp_pkg::tile_type               h_ff, h_in;

   assign h_en     = !h_valid_ff || out_ready;
   assign g_en     = !g_valid_ff || h_en;
   assign f_en     = !f_valid_ff || g_en;
   assign in_ready = f_en;

   // Stage F: distances and first tree level.
   always_comb begin
      list[0].dxo      = 2'sd0;
      list[0].dyo      = 2'sd0;
      list[0].range_sq = hxp_pkg::START_SQ;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            list[i * 3 + j + 1].dxo      = 2'(i - 1);
            list[i * 3 + j + 1].dyo      = 2'(j - 1);
            list[i * 3 + j + 1].range_sq = hxp_pkg::DIST_W'(in_beat.ax_sq[2 * i + j])
                                         + hxp_pkg::DIST_W'(in_beat.ay_sq[j]);
         end
      end
      for (int n = 0; n < 5; n++)
         f_pick_in[n] = hxp_pkg::pick(list[2 * n], list[2 * n + 1]);
   end

   // Stage G: two more levels.
   always_comb begin
      q0 = hxp_pkg::pick(f_pick_ff[0], f_pick_ff[1]);
      q1 = hxp_pkg::pick(f_pick_ff[2], f_pick_ff[3]);
      g_r0_in = hxp_pkg::pick(q0, q1);
   end

   // Stage H: last compare, apply the neighbor offset, saturate.
   always_comb begin
      win = hxp_pkg::pick(g_r0_ff, g_r1_ff);
      bx = hxp_pkg::M_W'(g_gx_ff) + hxp_pkg::M_W'(win.dxo);
      by = hxp_pkg::M_W'(g_gy_ff) + hxp_pkg::M_W'(win.dyo);
      h_in.tile_x = hxp_pkg::sat_tile(bx);
      h_in.tile_y = hxp_pkg::sat_tile(by);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         if (f_en) f_valid_ff <= in_valid;
         if (g_en) g_valid_ff <= f_valid_ff;
         if (h_en) h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         for (int n = 0; n < 5; n++)
            f_pick_ff[n] <= f_pick_in[n];
         f_gx_ff <= in_beat.gx;
         f_gy_ff <= in_beat.gy;
      end
      if (g_en) begin
         g_r0_ff <= g_r0_in;
         g_r1_ff <= f_pick_ff[4];
         g_gx_ff <= f_gx_ff;
         g_gy_ff <= f_gy_ff;
      end
      if (h_en) h_ff <= h_in;
   end

   assign out_valid = h_valid_ff;
   assign out_beat  = h_ff;

endmodule

/* design/hxp_checker.sv */
// Port-level checker for the hex tile pick top, attached with a bind.
// Depends on hxp_pkg for the pipeline depth.
module hxp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [hxp_pkg::TILE_W-1:0] tile_x,
   input logic signed [hxp_pkg::TILE_W-1:0] tile_y
);

   logic [hxp_pkg::CNT_W-1:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff
                  + hxp_pkg::CNT_W'(req_valid && req_ready)
                  - hxp_pkg::CNT_W'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset)
         inflight_ff <= '0;
      else
         inflight_ff <= inflight_in;
   end

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tile_x) && $stable(tile_y))
      else $error("response beat changed while stalled");

   // Nothing comes out that was not taken in.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= hxp_pkg::CNT_W'(hxp_pkg::PIPE_DEPTH))
      else $error("more beats in flight than pipeline stages");

   // With the sink taking beats, no stage can be stuck, so the input is open.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

endmodule

bind pixel_to_hex_tile_pick_top hxp_checker u_hxp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .tile_x    (rsp_bus.tile_x),
   .tile_y    (rsp_bus.tile_y)
);

/* tb/pixel_to_hex_tile_pick_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for pixel_to_hex_tile_pick_top: screen positions in, nearest axial tile out.
// Holds its own nearest-tile predictor; needs hxp_pkg, hxp_req_if, hxp_rsp_if and the design.

module pixel_to_hex_tile_pick_top_test;

   localparam int     POS_W         = hxp_pkg::POS_W;
   localparam int     TILE_W        = hxp_pkg::TILE_W;
   localparam longint ROOT3_Q20     = 1816187;   // sqrt(3) in Q20
   localparam longint SIDE          = hxp_pkg::SIDE_LENGTH;
   localparam longint FSCALE        = longint'(1) << hxp_pkg::FRAC_BITS;
   localparam longint ROW_PITCH     = 3 * SIDE * FSCALE / 2;
   localparam longint POS_MAX       = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_MIN       = -(longint'(1) << (POS_W - 1));
   localparam longint TILE_MAX      = (longint'(1) << (TILE_W - 1)) - 1;
   localparam longint TILE_MIN      = -(longint'(1) << (TILE_W - 1));
   localparam int     SETTLE_CYCLES = 24;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     MAX_PRINTED   = 40;

   typedef struct {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      hxp_pkg::tile_type       tile;
   } tile_expect_type;

   logic clock;
   logic reset;

   hxp_req_if req_bus ();
   hxp_rsp_if rsp_bus ();

   tile_expect_type pending_tiles[$];
   int req_gap_max    = 12;
   int rsp_stall_max  = 12;
   int sent_count     = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int cycles         = 0;

   pixel_to_hex_tile_pick_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   // Offset magnitude in distance units: drop 12 bits, hold at 2^30.
   function automatic longint unsigned offset_mag(input longint d);
      longint unsigned m;
      m = (d < 0) ? -d : d;
      m = m >> 12;
      if (m > (longint'(1) << 30))
         m = longint'(1) << 30;
      return m;
   endfunction

   function automatic logic signed [TILE_W-1:0] clamp_tile(input longint v);
      if (v > TILE_MAX)
         v = TILE_MAX;
      if (v < TILE_MIN)
         v = TILE_MIN;
      return v[TILE_W-1:0];
   endfunction

   function automatic hxp_pkg::tile_type nearest_tile(input logic signed [POS_W-1:0] pos_x,
                                                      input logic signed [POS_W-1:0] pos_y);
      longint px, py, gx, gy, bx, by, cx, cy, dx, dy;
      longint unsigned ax, ay, sq_dist, best, start_mag;
      hxp_pkg::tile_type t;
      px = pos_x;
      py = pos_y;
      // SV signed division truncates toward zero, as the guess requires
      gx = (ROOT3_Q20 * px - py * (longint'(1) << 20))
           / (3 * SIDE * FSCALE * (longint'(1) << 20));
      gy = (2 * py) / (3 * SIDE * FSCALE);
      start_mag = (20 * SIDE * FSCALE) << 9;
      best = start_mag * start_mag;
      bx = gx;
      by = gy;
      for (cx = gx - 1; cx <= gx + 1; cx++) begin
         for (cy = gy - 1; cy <= gy + 1; cy++) begin
            dx = px * (longint'(1) << 21) - ROOT3_Q20 * SIDE * (2 * cx + cy) * FSCALE;
            dy = py * (longint'(1) << 21) - 3 * SIDE * cy * FSCALE * (longint'(1) << 20);
            ax = offset_mag(dx);
            ay = offset_mag(dy);
            sq_dist = ax * ax + ay * ay;
            // strict compare: earlier candidate keeps a tie
            if (sq_dist < best) begin
               best = sq_dist;
               bx = cx;
               by = cy;
            end
         end
      end
      t.tile_x = clamp_tile(bx);
      t.tile_y = clamp_tile(by);
      return t;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > POS_MAX)
         v = POS_MAX;
      if (v < POS_MIN)
         v = POS_MIN;
      return v[POS_W-1:0];
   endfunction

   // x of a tile centre in position units, m = 2x + y
   function automatic longint tile_centre_x(input longint m);
      return (ROOT3_Q20 * SIDE * FSCALE * m) / (longint'(1) << 21);
   endfunction

   function automatic void random_position(input int near_pct,
                                          output logic signed [POS_W-1:0] px,
                                          output logic signed [POS_W-1:0] py);
      longint ty, m, reach;
      longint edges[4] = '{POS_MIN, -1, 0, POS_MAX};
      logic [31:0] bits;
      if ($urandom_range(0, 99) < near_pct) begin
         ty = longint'($urandom_range(0, 1200)) - 600;
         m  = longint'($urandom_range(0, 2000)) - 1000;
         if ((m - ty) % 2 != 0)
            m = m - 1;   // 2x + y shares parity with y
         reach = ($urandom_range(0, 3) == 0) ? 8 : 700;
         px = clamp_pos(tile_centre_x(m)
                        + longint'($urandom_range(0, 32'(2 * reach))) - reach);
         py = clamp_pos(ty * ROW_PITCH
                        + longint'($urandom_range(0, 32'(2 * reach))) - reach);
      end else if ($urandom_range(0, 15) == 0) begin
         px = clamp_pos(edges[$urandom_range(0, 3)]);
         py = clamp_pos(edges[$urandom_range(0, 3)]);
      end else begin
         bits = $urandom();
         px = bits[POS_W-1:0];
         bits = $urandom();
         py = bits[POS_W-1:0];
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic send_position(input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py);
      int gap;
      tile_expect_type entry;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= px;
      req_bus.pos_y <= py;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      entry.pos_x = px;
      entry.pos_y = py;
      entry.tile  = nearest_tile(px, py);
      pending_tiles.push_back(entry);
      sent_count++;
   endtask

   task automatic send_tile_centre(input longint tx, input longint ty);
      send_position(clamp_pos(tile_centre_x(2 * tx + ty)), clamp_pos(ty * ROW_PITCH));
   endtask

   task automatic send_random(input int count, input int near_pct);
      logic signed [POS_W-1:0] px, py;
      repeat (count) begin
         random_position(near_pct, px, py);
         send_position(px, py);
      end
   endtask

   task automatic drain_results(input int settle);
      req_bus.valid <= 1'b0;
      while (pending_tiles.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_field_extremes();
      req_gap_max   = 12;
      rsp_stall_max = 12;
      send_position(POS_W'(0), POS_W'(0));
      send_position(clamp_pos(POS_MAX), clamp_pos(POS_MAX));
      send_position(clamp_pos(POS_MIN), clamp_pos(POS_MIN));
      send_position(clamp_pos(POS_MAX), clamp_pos(POS_MIN));
      send_position(clamp_pos(POS_MIN), clamp_pos(POS_MAX));
      send_position(POS_W'(-1), POS_W'(-1));
      send_position(POS_W'(1), POS_W'(0));
      send_position(POS_W'(0), POS_W'(-1));
   endtask

   task automatic test_tile_centres();
      send_tile_centre(1, 0);
      send_tile_centre(0, 1);
      send_tile_centre(-1, -1);
      send_tile_centre(3, -2);
      send_tile_centre(-400, 500);
   endtask

   // Edges, corners where three tiles meet, and guesses that truncate toward zero.
   task automatic test_tile_boundaries();
      send_position(POS_W'(498), POS_W'(0));
      send_position(POS_W'(499), POS_W'(0));
      send_position(POS_W'(0), POS_W'(576));
      send_position(POS_W'(499), POS_W'(288));
      send_position(POS_W'(0), POS_W'(863));
      send_position(POS_W'(0), POS_W'(-864));
      send_position(POS_W'(-998), POS_W'(0));
      send_position(POS_W'(997), POS_W'(0));
   endtask

   task automatic test_random_spread();
      req_gap_max   = 12;
      rsp_stall_max = 12;
      send_random(600, 0);
   endtask

   task automatic test_random_near_tiles();
      req_gap_max   = 12;
      rsp_stall_max = 12;
      send_random(600, 100);
   endtask

   task automatic test_back_to_back();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      send_random(300, 50);
   endtask

   task automatic test_backpressure();
      req_gap_max   = 0;
      rsp_stall_max = 12;
      send_random(200, 50);
   endtask

   task automatic test_drain_pause();
      req_gap_max   = 3;
      rsp_stall_max = 6;
      send_random(100, 70);
      drain_results(0);
      send_random(100, 70);
   endtask

   // ---------------------------------------------------------------- result checker

   initial begin : tile_checker
      tile_expect_type want;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (rsp_bus.valid !== 1'b1)
            @(posedge clock);
         checked_count++;
         if (pending_tiles.size() == 0) begin
            report_mismatch($sformatf("tile (%0d, %0d) with no position pending",
                                      rsp_bus.tile_x, rsp_bus.tile_y));
         end else begin
            want = pending_tiles.pop_front();
            if (rsp_bus.tile_x !== want.tile.tile_x)
               report_mismatch($sformatf("pos (%0d, %0d): tile_x %0d, predicted %0d",
                                         want.pos_x, want.pos_y,
                                         rsp_bus.tile_x, want.tile.tile_x));
            if (rsp_bus.tile_y !== want.tile.tile_y)
               report_mismatch($sformatf("pos (%0d, %0d): tile_y %0d, predicted %0d",
                                         want.pos_x, want.pos_y,
                                         rsp_bus.tile_y, want.tile.tile_y));
         end
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d tiles outstanding", cycles, pending_tiles.size());
      $display("** pixel_to_hex_tile_pick_top: FAILED **");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_tile_centres();
      test_tile_boundaries();
      test_random_spread();
      test_random_near_tiles();
      test_back_to_back();
      test_backpressure();
      test_drain_pause();

      drain_results(SETTLE_CYCLES);
      $display("%0d positions sent: field corners, tile centres, edges and corners, wide and",
               sent_count);
      $display("near-tile random, with gaps, stalls, full-rate and drained phases; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("** pixel_to_hex_tile_pick_top: PASSED **");
      else
         $display("** pixel_to_hex_tile_pick_top: FAILED **");
      $finish;
   end

endmodule
